// ===== rtl/glaw_pkg.sv =====
// Package for the grid line address walker: grid geometry constants,
// field widths, the multiply-add control type and the size clamp function.
// No dependencies.
`timescale 1ns / 1ps

package glaw_pkg;

	// Grid geometry
	localparam int DIMS       = 4;
	localparam int MAX_EXTENT = 64;

	// Field widths
	localparam int IN_W   = 7;
	localparam int IDX_W  = 6;
	localparam int ADDR_W = 24;
	localparam int CNT_W  = 7;
	localparam int DIM_W  = (DIMS > 1) ? $clog2(DIMS) : 1;

	localparam logic [DIM_W-1:0] DIM_LAST = DIM_W'(DIMS - 1);
	localparam logic [IN_W-1:0]  EXT_MAX  = IN_W'(MAX_EXTENT);
	localparam logic [IN_W-1:0]  SIZE_RST = IN_W'(64);

	// Control of the shared multiply-add unit
	typedef struct packed {
		logic en;    // update the accumulator this cycle
		logic first; // load the index instead of accumulating
	} mac_ctl_t;

	// A size of zero counts as one, a size above the maximum as the maximum.
	function automatic logic [IN_W-1:0] eff_size(input logic [IN_W-1:0] s);
		logic [IN_W-1:0] r;
		r = s;
		if (s == '0) begin
			r = IN_W'(1);
		end else if (s > EXT_MAX) begin
			r = EXT_MAX;
		end
		return r;
	endfunction

endpackage

// ===== rtl/grid_line_address_walker.sv =====
// Top level of the grid line address walker: request intake, sequencer,
// per-dimension walk state and the output register.
// Depends on glaw_pkg and glaw_mac.
`timescale 1ns / 1ps

// Usage:
// A request carries a one-based start and end for each of the four grid
// dimensions and is taken when in_valid and in_ready are both high. The
// block then walks a line of points and offers one result per point on the
// out channel (valid/ready): the zero-based index per dimension, the
// row-major linear address and a last_point flag on the final point. A
// request with any start of zero is taken and yields no result.
// Sequence: after intake, the sequencer clamps the bounds of each dimension in
// turn, then for each point forms the address, which the shared multiply-add
// unit builds one dimension per cycle, and then loads the output register.
// in_ready is high only while the block is idle, so a new request is not
// taken before the walk of the last one is through.
// A stalled receiver holds the output register; the walk waits with the
// next point ready until the register frees up. The grid sizes are written
// through cfg_we / cfg_index / cfg_data and reset to 64; the user must write
// them only while idle, which the block itself does not enforce.
// Reset (arst_n low) returns the sequencer to idle with no result pending.

module grid_line_address_walker (
	input  logic                          clk,
	input  logic                          arst_n,
	// Configuration writes
	input  logic                          cfg_we,
	input  logic [glaw_pkg::DIM_W-1:0]    cfg_index,
	input  logic [glaw_pkg::IN_W-1:0]     cfg_data,
	// Request channel
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [glaw_pkg::IN_W-1:0]     start_d0,
	input  logic [glaw_pkg::IN_W-1:0]     end_d0,
	input  logic [glaw_pkg::IN_W-1:0]     start_d1,
	input  logic [glaw_pkg::IN_W-1:0]     end_d1,
	input  logic [glaw_pkg::IN_W-1:0]     start_d2,
	input  logic [glaw_pkg::IN_W-1:0]     end_d2,
	input  logic [glaw_pkg::IN_W-1:0]     start_d3,
	input  logic [glaw_pkg::IN_W-1:0]     end_d3,
	// Result channel
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [glaw_pkg::IDX_W-1:0]    index_d0,
	output logic [glaw_pkg::IDX_W-1:0]    index_d1,
	output logic [glaw_pkg::IDX_W-1:0]    index_d2,
	output logic [glaw_pkg::IDX_W-1:0]    index_d3,
	output logic [glaw_pkg::ADDR_W-1:0]   linear_address,
	output logic                          last_point
);
	import glaw_pkg::*;

	// Sequencer states
	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_SETUP = 2'd1;
	localparam logic [1:0] S_ADDR  = 2'd2;
	localparam logic [1:0] S_PUSH  = 2'd3;

	logic [1:0]       state_q;
	logic [DIM_W-1:0] dim_q;
	logic [CNT_W-1:0] left_q;
	logic             out_valid_q;

	logic [IN_W-1:0]  size_q  [DIMS];
	logic [IN_W-1:0]  start_q [DIMS];
	logic [IN_W-1:0]  end_q   [DIMS];
	logic [IN_W-1:0]  in_start [DIMS];
	logic [IN_W-1:0]  in_end   [DIMS];

	logic [IDX_W-1:0] cur_q   [DIMS];
	logic [IDX_W-1:0] first_q [DIMS];
	logic [IDX_W-1:0] last_q  [DIMS];
	logic             down_q  [DIMS];
	logic [IDX_W-1:0] cur_next [DIMS];

	logic [IDX_W-1:0]  idx_out_q [DIMS];
	logic [ADDR_W-1:0] addr_out_q;
	logic              last_out_q;

	logic              in_fire;
	logic              empty_req;
	logic              push_go;
	logic              push_last;
	mac_ctl_t          mac_ctl;
	logic [ADDR_W-1:0] mac_acc;

	// Setup datapath signals for the dimension under work
	logic [IN_W-1:0]  sz;
	logic [IN_W-1:0]  s_clamp;
	logic [IN_W-1:0]  e_clamp;
	logic             s_down;
	logic [CNT_W-1:0] span;

	assign in_start[0] = start_d0;
	assign in_start[1] = start_d1;
	assign in_start[2] = start_d2;
	assign in_start[3] = start_d3;
	assign in_end[0]   = end_d0;
	assign in_end[1]   = end_d1;
	assign in_end[2]   = end_d2;
	assign in_end[3]   = end_d3;

	assign in_ready = (state_q == S_IDLE);
	assign in_fire  = in_valid && in_ready;

	// A request with any start of zero produces nothing.
	always_comb begin
		empty_req = 1'b0;
		for (int d = 0; d < DIMS; d++) begin
			if (in_start[d] == '0) begin
				empty_req = 1'b1;
			end
		end
	end

	// Clamp the bounds of one dimension and measure its span.
	always_comb begin
		sz      = eff_size(size_q[dim_q]);
		s_clamp = (start_q[dim_q] > sz) ? sz : start_q[dim_q];
		if (end_q[dim_q] == '0) begin
			e_clamp = IN_W'(1);
		end else if (end_q[dim_q] > sz) begin
			e_clamp = sz;
		end else begin
			e_clamp = end_q[dim_q];
		end
		s_down = (e_clamp < s_clamp);
		span   = s_down ? CNT_W'(s_clamp - e_clamp + IN_W'(1))
		                : CNT_W'(e_clamp - s_clamp + IN_W'(1));
	end

	// Next index of every dimension: wrap at the end, otherwise step.
	always_comb begin
		for (int d = 0; d < DIMS; d++) begin
			if (cur_q[d] == last_q[d]) begin
				cur_next[d] = first_q[d];
			end else if (down_q[d]) begin
				cur_next[d] = cur_q[d] - IDX_W'(1);
			end else begin
				cur_next[d] = cur_q[d] + IDX_W'(1);
			end
		end
	end

	// The output register takes a point when it is empty or being drained.
	assign push_go   = (state_q == S_PUSH) && (!out_valid_q || out_ready);
	assign push_last = (left_q == CNT_W'(1));

	// Multiply-add control: dimension DIMS-1 loads, the rest accumulate.
	always_comb begin
		mac_ctl.en    = (state_q == S_ADDR);
		mac_ctl.first = (dim_q == DIM_LAST);
	end

	glaw_mac u_mac (
		.clk   (clk),
		.ctl   (mac_ctl),
		.index (cur_q[dim_q]),
		.size  (eff_size(size_q[dim_q])),
		.acc   (mac_acc)
	);

	// Size registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int d = 0; d < DIMS; d++) begin
				size_q[d] <= SIZE_RST;
			end
		end else if (cfg_we && ({1'b0, cfg_index} < (DIM_W+1)'(DIMS))) begin
			size_q[cfg_index] <= cfg_data;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			dim_q       <= '0;
			left_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// A drained result frees the register unless a new point takes it.
			if (out_valid_q && out_ready && !push_go) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						left_q <= '0;
						dim_q  <= '0;
						if (!empty_req) begin
							state_q <= S_SETUP;
						end
					end
				end
				S_SETUP: begin
					if (span > left_q) begin
						left_q <= span;
					end
					if (dim_q == DIM_LAST) begin
						state_q <= S_ADDR;
					end else begin
						dim_q <= dim_q + DIM_W'(1);
					end
				end
				S_ADDR: begin
					if (dim_q == '0) begin
						state_q <= S_PUSH;
					end else begin
						dim_q <= dim_q - DIM_W'(1);
					end
				end
				S_PUSH: begin
					if (push_go) begin
						out_valid_q <= 1'b1;
						left_q      <= left_q - CNT_W'(1);
						dim_q       <= DIM_LAST;
						state_q     <= push_last ? S_IDLE : S_ADDR;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Request capture and per-dimension walk state
	always_ff @(posedge clk) begin
		if (in_fire) begin
			for (int d = 0; d < DIMS; d++) begin
				start_q[d] <= in_start[d];
				end_q[d]   <= in_end[d];
			end
		end
		if (state_q == S_SETUP) begin
			first_q[dim_q] <= IDX_W'(s_clamp - IN_W'(1));
			last_q[dim_q]  <= IDX_W'(e_clamp - IN_W'(1));
			cur_q[dim_q]   <= IDX_W'(s_clamp - IN_W'(1));
			down_q[dim_q]  <= s_down;
		end else if (push_go && !push_last) begin
			for (int d = 0; d < DIMS; d++) begin
				cur_q[d] <= cur_next[d];
			end
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (push_go) begin
			for (int d = 0; d < DIMS; d++) begin
				idx_out_q[d] <= cur_q[d];
			end
			addr_out_q <= mac_acc;
			last_out_q <= push_last;
		end
	end

	assign out_valid      = out_valid_q;
	assign index_d0       = idx_out_q[0];
	assign index_d1       = idx_out_q[1];
	assign index_d2       = idx_out_q[2];
	assign index_d3       = idx_out_q[3];
	assign linear_address = addr_out_q;
	assign last_point     = last_out_q;

`ifndef SYNTHESIS
	// No points remain counted while the block is idle.
	a_idle_no_left: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (left_q == '0))
		else $error("walker idle with points outstanding");

	// While a walk is under way at least one point remains.
	a_walk_has_left: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ADDR || state_q == S_PUSH) |-> (left_q != '0))
		else $error("walker running with no points left");

	// A held result is never overwritten.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> !push_go)
		else $error("output register overwritten while stalled");

	// The final point returns the sequencer to idle.
	a_last_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(push_go && push_last) |=> (state_q == S_IDLE && out_valid_q && last_out_q))
		else $error("final point did not end the walk");
`endif

endmodule

// ===== rtl/glaw_mac.sv =====
// Shared multiply-add unit of the grid line address walker.
// Forms the row-major address by Horner steps, one dimension per cycle while ctl.en is high.
// Depends on glaw_pkg.
`timescale 1ns / 1ps

module glaw_mac (
	input  logic                         clk,
	input  glaw_pkg::mac_ctl_t           ctl,
	input  logic [glaw_pkg::IDX_W-1:0]   index,
	input  logic [glaw_pkg::IN_W-1:0]    size,
	output logic [glaw_pkg::ADDR_W-1:0]  acc
);
	import glaw_pkg::*;

	logic [ADDR_W-1:0]      acc_q;
	logic [ADDR_W+IN_W-1:0] prod;
	logic [ADDR_W-1:0]      sum;

	// One multiply and one add per cycle, kept to the address width.
	always_comb begin
		prod = acc_q * size;
		sum  = prod[ADDR_W-1:0] + ADDR_W'(index);
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			acc_q <= ctl.first ? ADDR_W'(index) : sum;
		end
	end

	assign acc = acc_q;

endmodule

// ===== tb/sv/grid_line_address_walker_tb.sv =====
// Testbench for grid_line_address_walker: drives range requests and grid sizes,
// predicts every walked point and checks indices, address and last flag.
// Depends on glaw_pkg and the grid_line_address_walker RTL.
`timescale 1ns / 1ps

module grid_line_address_walker_tb;
	import glaw_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SETTLE_CYCLES  = 20;
	localparam int RANDOM_POINTS_PER_PHASE = 36;

	// Register indexes of the configuration port.
	typedef enum logic [DIM_W-1:0] {
		SIZE_DIM0,
		SIZE_DIM1,
		SIZE_DIM2,
		SIZE_DIM3
	} size_reg_e;

	typedef struct packed {
		logic [DIMS-1:0][IN_W-1:0] start_pos;
		logic [DIMS-1:0][IN_W-1:0] end_pos;
	} range_req_t;

	typedef struct packed {
		logic [DIMS-1:0][IDX_W-1:0] index;
		logic [ADDR_W-1:0]          addr;
		logic                       last;
	} grid_point_t;

	// Keeps its own copy of the grid sizes, walks each accepted request and
	// holds the points the block has still to deliver.
	class line_walk_checker;
		logic [IN_W-1:0] size [DIMS];
		grid_point_t     expected_points [$];
		int              errors;

		function new();
			for (int d = 0; d < DIMS; d++) begin
				size[d] = SIZE_RST;
			end
			errors = 0;
		endfunction

		// Size as the block uses it: zero counts as one, large values saturate.
		function int unsigned extent(int d);
			if (size[d] == '0) begin
				return 1;
			end
			if (size[d] > MAX_EXTENT) begin
				return MAX_EXTENT;
			end
			return size[d];
		endfunction

		function int pending();
			return expected_points.size();
		endfunction

		function void fail(string msg);
			errors++;
			if (errors <= 30) begin
				$display("%0t: %s", $time, msg);
			end
		endfunction

		// Walk one accepted request and queue every point it yields.
		function void add_request(range_req_t r);
			int unsigned lo [DIMS];
			int unsigned hi [DIMS];
			int unsigned cur [DIMS];
			int unsigned fac [DIMS];
			bit          down [DIMS];
			int unsigned count;
			int unsigned span;
			int unsigned addr;
			grid_point_t p;
			// A zero start in any dimension means an empty request.
			for (int d = 0; d < DIMS; d++) begin
				if (r.start_pos[d] == '0) begin
					return;
				end
			end
			count = 0;
			for (int d = 0; d < DIMS; d++) begin
				lo[d] = (r.start_pos[d] > extent(d)) ? extent(d) : r.start_pos[d];
				hi[d] = r.end_pos[d];
				if (hi[d] < 1) begin
					hi[d] = 1;
				end
				if (hi[d] > extent(d)) begin
					hi[d] = extent(d);
				end
				down[d] = (hi[d] < lo[d]);
				span = down[d] ? (lo[d] - hi[d] + 1) : (hi[d] - lo[d] + 1);
				if (span > count) begin
					count = span;
				end
				cur[d] = lo[d] - 1;
				fac[d] = (d == 0) ? 1 : fac[d-1] * extent(d - 1);
			end
			for (int unsigned n = 0; n < count; n++) begin
				// Step every dimension; one standing on its end goes back to its start.
				if (n != 0) begin
					for (int d = 0; d < DIMS; d++) begin
						if (cur[d] == hi[d] - 1) begin
							cur[d] = lo[d] - 1;
						end else if (down[d]) begin
							cur[d] = cur[d] - 1;
						end else begin
							cur[d] = cur[d] + 1;
						end
					end
				end
				addr = 0;
				for (int d = 0; d < DIMS; d++) begin
					p.index[d] = IDX_W'(cur[d]);
					addr += cur[d] * fac[d];
				end
				p.addr = ADDR_W'(addr);
				p.last = (n + 1 == count);
				expected_points.push_back(p);
			end
		endfunction

		// Compare one delivered point with the oldest expected one.
		function void check_point(grid_point_t got);
			grid_point_t want;
			if (expected_points.size() == 0) begin
				fail($sformatf("point with nothing expected: address expected none, got %0d",
					got.addr));
				return;
			end
			want = expected_points.pop_front();
			for (int d = 0; d < DIMS; d++) begin
				if (got.index[d] !== want.index[d]) begin
					fail($sformatf("index_d%0d: expected %0d, got %0d", d, want.index[d],
						got.index[d]));
				end
			end
			if (got.addr !== want.addr) begin
				fail($sformatf("linear_address: expected %0d, got %0d", want.addr, got.addr));
			end
			if (got.last !== want.last) begin
				fail($sformatf("last_point: expected %0d, got %0d", want.last, got.last));
			end
		endfunction
	endclass

	logic                       clk;
	logic                       arst_n    = 1'b0;
	logic                       cfg_we    = 1'b0;
	logic [DIM_W-1:0]           cfg_index = '0;
	logic [IN_W-1:0]            cfg_data  = '0;
	logic                       in_valid  = 1'b0;
	logic                       in_ready;
	logic [IN_W-1:0]            start_d0  = '0;
	logic [IN_W-1:0]            end_d0    = '0;
	logic [IN_W-1:0]            start_d1  = '0;
	logic [IN_W-1:0]            end_d1    = '0;
	logic [IN_W-1:0]            start_d2  = '0;
	logic [IN_W-1:0]            end_d2    = '0;
	logic [IN_W-1:0]            start_d3  = '0;
	logic [IN_W-1:0]            end_d3    = '0;
	logic                       out_valid;
	logic                       out_ready = 1'b0;
	logic [IDX_W-1:0]           index_d0;
	logic [IDX_W-1:0]           index_d1;
	logic [IDX_W-1:0]           index_d2;
	logic [IDX_W-1:0]           index_d3;
	logic [ADDR_W-1:0]          linear_address;
	logic                       last_point;

	line_walk_checker sb;
	int               tx_idle_pct  = 25;
	int               rx_idle_pct  = 51;
	int               quiet_cycles = 0;
	grid_point_t      seen_point;

	grid_line_address_walker dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.start_d0       (start_d0),
		.end_d0         (end_d0),
		.start_d1       (start_d1),
		.end_d1         (end_d1),
		.start_d2       (start_d2),
		.end_d2         (end_d2),
		.start_d3       (start_d3),
		.end_d3         (end_d3),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.index_d0       (index_d0),
		.index_d1       (index_d1),
		.index_d2       (index_d2),
		.index_d3       (index_d3),
		.linear_address (linear_address),
		.last_point     (last_point)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Receiver stalls at the rate of the current phase.
	always @(posedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
	end

	// Check every accepted point.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			seen_point.index[0] = index_d0;
			seen_point.index[1] = index_d1;
			seen_point.index[2] = index_d2;
			seen_point.index[3] = index_d3;
			seen_point.addr     = linear_address;
			seen_point.last     = last_point;
			sb.check_point(seen_point);
		end
	end

	// Watchdog: ends the run when no handshake happens for too long.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("grid_line_address_walker_tb: errors");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic range_req_t make_req(
		input logic [IN_W-1:0] s0, input logic [IN_W-1:0] e0,
		input logic [IN_W-1:0] s1, input logic [IN_W-1:0] e1,
		input logic [IN_W-1:0] s2, input logic [IN_W-1:0] e2,
		input logic [IN_W-1:0] s3, input logic [IN_W-1:0] e3);
		range_req_t r;
		r.start_pos[0] = s0;
		r.end_pos[0]   = e0;
		r.start_pos[1] = s1;
		r.end_pos[1]   = e1;
		r.start_pos[2] = s2;
		r.end_pos[2]   = e2;
		r.start_pos[3] = s3;
		r.end_pos[3]   = e3;
		return r;
	endfunction

	// Mostly bounds inside the grid, sometimes zero ends and values past the size.
	function automatic logic [IN_W-1:0] pick_bound(input int d, input bit is_end);
		int r;
		r = $urandom_range(0, 99);
		if (is_end && r < 6) begin
			return '0;
		end
		if (r < 12) begin
			return IN_W'($urandom_range(65, 127));
		end
		if (r < 25) begin
			return IN_W'($urandom_range(1, MAX_EXTENT));
		end
		return IN_W'($urandom_range(1, sb.extent(d)));
	endfunction

	function automatic range_req_t random_req();
		range_req_t r;
		for (int d = 0; d < DIMS; d++) begin
			r.start_pos[d] = pick_bound(d, 1'b0);
			r.end_pos[d]   = pick_bound(d, 1'b1);
		end
		// A few empty requests with a zero start in one dimension.
		if ($urandom_range(0, 99) < 8) begin
			r.start_pos[$urandom_range(0, DIMS - 1)] = '0;
		end
		return r;
	endfunction

	task automatic send_request(input range_req_t r);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		start_d0 <= r.start_pos[0];
		end_d0   <= r.end_pos[0];
		start_d1 <= r.start_pos[1];
		end_d1   <= r.end_pos[1];
		start_d2 <= r.start_pos[2];
		end_d2   <= r.end_pos[2];
		start_d3 <= r.start_pos[3];
		end_d3   <= r.end_pos[3];
		do @(posedge clk); while (!in_ready);
		sb.add_request(r);
	endtask

	// Drop valid, wait for every expected point, then let the block settle.
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes follow back to back; the write enable stays high between them.
	task automatic write_size(input size_reg_e idx, input logic [IN_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		sb.size[idx] = value;
	endtask

	task automatic write_sizes(input logic [IN_W-1:0] v0, input logic [IN_W-1:0] v1,
		input logic [IN_W-1:0] v2, input logic [IN_W-1:0] v3);
		write_size(SIZE_DIM0, v0);
		write_size(SIZE_DIM1, v1);
		write_size(SIZE_DIM2, v2);
		write_size(SIZE_DIM3, v3);
		cfg_we <= 1'b0;
	endtask

	task automatic random_phase();
		range_req_t r;
		int         walked;
		walked = 0;
		while (walked < RANDOM_POINTS_PER_PHASE) begin
			r = random_req();
			send_request(r);
			if (r.start_pos[0] != '0 && r.start_pos[1] != '0 &&
				r.start_pos[2] != '0 && r.start_pos[3] != '0) begin
				walked++;
			end
		end
		drain();
	endtask

	initial begin
		sb = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed requests with the reset sizes of 64.
		send_request(make_req(1, 64, 1, 64, 1, 64, 1, 64));
		send_request(make_req(64, 1, 64, 1, 64, 1, 64, 1));
		send_request(make_req(1, 1, 1, 1, 1, 1, 1, 1));
		send_request(make_req(64, 64, 64, 64, 64, 64, 64, 64));
		send_request(make_req(3, 0, 2, 0, 1, 0, 5, 0));
		send_request(make_req(127, 127, 127, 127, 127, 127, 127, 127));
		send_request(make_req(1, 10, 5, 3, 7, 7, 64, 60));
		send_request(make_req(10, 1, 4, 2, 1, 3, 2, 2));
		send_request(make_req(85, 42, 42, 85, 85, 42, 42, 85));
		send_request(make_req(1, 100, 64, 0, 20, 127, 33, 30));
		send_request(make_req(0, 10, 1, 10, 1, 10, 1, 10));
		send_request(make_req(5, 10, 5, 10, 5, 10, 0, 10));
		send_request(make_req(0, 0, 0, 0, 0, 0, 0, 0));
		send_request(make_req(60, 64, 2, 1, 30, 35, 63, 64));
		drain();

		// Random requests: both sides idle, extreme sizes first.
		write_sizes(1, 1, 1, 1);
		random_phase();
		write_sizes(64, 64, 64, 64);
		random_phase();

		// Idle rates swapped; sizes out of range and random.
		tx_idle_pct = 51;
		rx_idle_pct = 25;
		write_sizes(0, 127, 65, 3);
		random_phase();
		write_sizes(IN_W'($urandom_range(1, 64)), IN_W'($urandom_range(1, 64)),
			IN_W'($urandom_range(1, 64)), IN_W'($urandom_range(1, 64)));
		random_phase();

		// No idling on either side.
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		write_sizes(5, 1, 64, 2);
		random_phase();
		write_sizes(IN_W'($urandom_range(0, 127)), IN_W'($urandom_range(0, 127)),
			IN_W'($urandom_range(0, 127)), IN_W'($urandom_range(0, 127)));
		random_phase();

		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("grid_line_address_walker_tb: clean");
		end else begin
			$display("grid_line_address_walker_tb: errors");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/glaw_pkg.sv
rtl/glaw_mac.sv
rtl/grid_line_address_walker.sv
tb/sv/grid_line_address_walker_tb.sv
